FILE: rtl/core/pmwq_pkg.sv
// ----------------------------------------------------------------------------
// pmwq_pkg: shared types and constants for the priority mutex wait queue
// Request codes, FSM states and the control/status bundles that pass
// between the sequencer and the wait-list store.
// ----------------------------------------------------------------------------
package pmwq_pkg;

	// Fixed field widths of the stream payload
	localparam int ID_W   = 3;
	localparam int PRIO_W = 3;

	// Default sizing
	localparam int DEF_MAX_TASKS       = 8;
	localparam int DEF_PRIORITY_LEVELS = 6;

	// Packed beat widths (whole bytes)
	localparam int S_DATA_W = 8;
	localparam int M_DATA_W = 16;

	// Request codes
	localparam logic OP_ACQUIRE = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DRAIN
	} pmwq_state_t;

	// Commands to the wait-list store
	typedef struct packed {
		logic push;
		logic pop;
	} q_cmd_t;

	// Status from the wait-list store
	typedef struct packed {
		logic any_waiting;
		logic id_waiting;
		logic pop_last;
	} q_stat_t;

endpackage

FILE: rtl/core/pmwq_queue.sv
// ----------------------------------------------------------------------------
// pmwq_queue: per-level FIFO wait lists
// Linked lists of waiting tasks, one per priority level, with a bitmap of
// non-empty levels and a waiting set. One push or one pop per cycle; a pop
// always takes the head of the highest non-empty level.
// ----------------------------------------------------------------------------
module pmwq_queue import pmwq_pkg::*; #(
	parameter int MAX_TASKS       = DEF_MAX_TASKS,
	parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS,
	localparam int TW = $clog2(MAX_TASKS),
	localparam int LW = $clog2(PRIORITY_LEVELS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  q_cmd_t        cmd,
	input  logic [LW-1:0] push_lvl,
	input  logic [TW-1:0] push_id,
	input  logic [TW-1:0] query_id,
	output logic [TW-1:0] pop_id,
	output q_stat_t       stat
);

	logic [PRIORITY_LEVELS-1:0] nonempty_q;
	logic [MAX_TASKS-1:0]       waiting_q;
	logic [TW-1:0]              head_q [PRIORITY_LEVELS];
	logic [TW-1:0]              tail_q [PRIORITY_LEVELS];
	logic [TW-1:0]              next_q [MAX_TASKS];

	logic [LW-1:0]              top_lv;
	logic [LW-1:0]              sel_lv;
	logic [TW-1:0]              head_rd;
	logic [TW-1:0]              tail_rd;
	logic                       hit_tail;
	logic [PRIORITY_LEVELS-1:0] clr_mask;
	logic [PRIORITY_LEVELS-1:0] lv_bit;

	// highest non-empty level
	always_comb begin
		top_lv = '0;
		for (int i = 0; i < PRIORITY_LEVELS; i++) begin
			if (nonempty_q[i]) begin
				top_lv = LW'(i);
			end
		end
	end

	// single shared list address: drain level on pop, request level otherwise
	assign sel_lv   = cmd.pop ? top_lv : push_lvl;
	assign head_rd  = head_q[sel_lv];
	assign tail_rd  = tail_q[sel_lv];
	assign hit_tail = (head_rd == tail_rd);
	assign lv_bit   = PRIORITY_LEVELS'(1) << sel_lv;
	assign clr_mask = hit_tail ? lv_bit : '0;

	assign pop_id           = head_rd;
	assign stat.any_waiting = |nonempty_q;
	assign stat.id_waiting  = waiting_q[query_id];
	assign stat.pop_last    = ((nonempty_q & ~clr_mask) == '0);

	// level bitmap and waiting set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonempty_q <= '0;
			waiting_q  <= '0;
		end else if (cmd.push) begin
			nonempty_q         <= nonempty_q | lv_bit;
			waiting_q[push_id] <= 1'b1;
		end else if (cmd.pop) begin
			nonempty_q         <= nonempty_q & ~clr_mask;
			waiting_q[head_rd] <= 1'b0;
		end
	end

	// list links, undefined until written
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			if (nonempty_q[sel_lv]) begin
				next_q[tail_rd] <= push_id;
			end else begin
				head_q[sel_lv] <= push_id;
			end
			tail_q[sel_lv] <= push_id;
		end else if (cmd.pop && !hit_tail) begin
			head_q[sel_lv] <= next_q[head_rd];
		end
	end

endmodule

FILE: rtl/core/priority_mutex_wait_queue_top.sv
// Each request beat is registered, decoded in S_EXEC and its result put in the output
// register; a new request waits until the last one is done. A release with waiters
// wakes them in S_DRAIN, one beat per cycle from the shared list port unless stalled.
// Output back-pressure stalls the sequencer; one result stays in the output register.
// Reset: arst_n clears lock, inheritance, level bitmap and waiting set; list
// links need no clearing, so no sweep runs after reset.
// ----------------------------------------------------------------------------
// priority_mutex_wait_queue_top: priority-ordered mutex with inheritance
// Single lock with per-priority FIFO wait lists; a release by the owner
// wakes every waiter, highest level first and FIFO within a level.
// ----------------------------------------------------------------------------
module priority_mutex_wait_queue_top import pmwq_pkg::*; #(
	parameter int MAX_TASKS       = DEF_MAX_TASKS,
	parameter int PRIORITY_LEVELS = DEF_PRIORITY_LEVELS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // task_id[2:0], task_priority[5:3]
	input  logic                s_tuser,  // operation[0]
	output logic                m_tvalid,
	input  logic                m_tready,
	// success[0], queued[1], woken_valid[2], woken_task[5:3],
	// inherit_active[6], inherit_prio[9:7]
	output logic [M_DATA_W-1:0] m_tdata,
	output logic                m_tlast
);

	localparam int TW = $clog2(MAX_TASKS);
	localparam int LW = $clog2(PRIORITY_LEVELS);

	pmwq_state_t state_q, state_nxt;

	// request registers
	logic              op_q;
	logic [ID_W-1:0]   id_q;
	logic [PRIO_W-1:0] pr_q;
	logic [PRIO_W-1:0] pr_sat;

	// lock state
	logic              held_q;
	logic [ID_W-1:0]   owner_q;
	logic [PRIO_W-1:0] owner_lvl_q;
	logic              inh_q;
	logic [PRIO_W-1:0] inh_lvl_q;

	// output register
	logic              m_tvalid_q;
	logic [9:0]        res_q;
	logic              last_q;

	// action decode
	logic              out_free;
	logic              res_load;
	logic [9:0]        res_d;
	logic              last_d;
	logic              id_bad;
	logic              grant;
	logic              refuse;
	logic              enqueue;
	logic              rel_ok;
	logic              inh_d;
	logic [PRIO_W-1:0] inh_lvl_d;
	logic              res_ok;
	logic              res_queued;
	logic              res_woken;
	logic [ID_W-1:0]   res_task;

	q_cmd_t            q_cmd;
	q_stat_t           q_stat;
	logic [TW-1:0]     pop_id;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, res_q};
	assign m_tlast  = last_q;
	assign out_free = !m_tvalid_q || m_tready;

	// priority saturation at the top level
	always_comb begin
		if (int'(s_tdata[5:3]) > PRIORITY_LEVELS - 1) begin
			pr_sat = PRIO_W'(PRIORITY_LEVELS - 1);
		end else begin
			pr_sat = s_tdata[5:3];
		end
	end

	// capture request beat
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q <= s_tuser;
			id_q <= s_tdata[2:0];
			pr_q <= pr_sat;
		end
	end

	// request classification
	assign id_bad  = (int'(id_q) >= MAX_TASKS);
	assign grant   = !id_bad && (op_q == OP_ACQUIRE) && !held_q;
	assign refuse  = id_bad
		|| ((op_q == OP_ACQUIRE) && held_q && ((id_q == owner_q) || q_stat.id_waiting))
		|| ((op_q == OP_RELEASE) && (!held_q || (id_q != owner_q)));
	assign enqueue = (op_q == OP_ACQUIRE) && held_q && !refuse;
	assign rel_ok  = (op_q == OP_RELEASE) && !refuse;

	// inheritance after an enqueue
	always_comb begin
		inh_d     = inh_q;
		inh_lvl_d = inh_lvl_q;
		if (enqueue && (pr_q > owner_lvl_q) && (!inh_q || (pr_q > inh_lvl_q))) begin
			inh_d     = 1'b1;
			inh_lvl_d = pr_q;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					if (rel_ok && q_stat.any_waiting) begin
						state_nxt = S_DRAIN;
					end else begin
						state_nxt = S_IDLE;
					end
				end
			end
			S_DRAIN: begin
				if (out_free && q_stat.pop_last) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// outputs of the sequencer: result beat and list commands
	always_comb begin
		res_load   = 1'b0;
		res_ok     = 1'b0;
		res_queued = 1'b0;
		res_woken  = 1'b0;
		res_task   = '0;
		last_d     = 1'b1;
		q_cmd      = '0;
		res_d      = '0;
		unique case (state_q)
			S_EXEC: begin
				if (out_free) begin
					q_cmd.push = enqueue;
					res_load   = !(rel_ok && q_stat.any_waiting);
					res_ok     = grant || rel_ok;
					res_queued = enqueue;
				end
			end
			S_DRAIN: begin
				if (out_free) begin
					q_cmd.pop = 1'b1;
					res_load  = 1'b1;
					res_ok    = 1'b1;
					res_woken = 1'b1;
					res_task  = ID_W'(pop_id);
					last_d    = q_stat.pop_last;
				end
			end
			default: begin
			end
		endcase
		res_d = {inh_d ? inh_lvl_d : {PRIO_W{1'b0}}, inh_d, res_task,
			res_woken, res_queued, res_ok};
	end

	// sequencer and lock state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			held_q      <= 1'b0;
			owner_q     <= '0;
			owner_lvl_q <= '0;
			inh_q       <= 1'b0;
			inh_lvl_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_EXEC && out_free) begin
				if (grant) begin
					held_q      <= 1'b1;
					owner_q     <= id_q;
					owner_lvl_q <= pr_q;
				end else if (rel_ok) begin
					held_q      <= 1'b0;
					owner_q     <= '0;
					owner_lvl_q <= '0;
				end
				inh_q     <= rel_ok ? 1'b0 : inh_d;
				inh_lvl_q <= rel_ok ? '0 : inh_lvl_d;
			end
		end
	end

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q  <= res_d;
			last_q <= last_d;
		end
	end

	pmwq_queue #(
		.MAX_TASKS       (MAX_TASKS),
		.PRIORITY_LEVELS (PRIORITY_LEVELS)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (q_cmd),
		.push_lvl (LW'(pr_q)),
		.push_id  (TW'(id_q)),
		.query_id (TW'(id_q)),
		.pop_id   (pop_id),
		.stat     (q_stat)
	);

	// draining only happens with waiters present
	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRAIN) |-> q_stat.any_waiting)
		else $error("drain state with empty wait lists");

	// a free lock has no waiters outside a drain
	a_free_no_waiters: assert property (@(posedge clk) disable iff (!arst_n)
		(!held_q && state_q != S_DRAIN) |-> !q_stat.any_waiting)
		else $error("waiters present on a free lock");

	// inheritance only on a held lock and above the owner level
	a_inherit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		inh_q |-> (held_q && (inh_lvl_q > owner_lvl_q)))
		else $error("inconsistent priority inheritance");

endmodule
